>>> rtl/thd_pkg.sv
// Shared types and constants for the tap/hold decision classifier.
`default_nettype none

package thd_pkg;

  // Configuration register map (word index on the APB port).
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_TAP_LIMIT = 2'd0;
  localparam logic [1:0] REG_CUE = 2'd1;
  localparam logic [1:0] REG_DENY = 2'd2;

  localparam logic [15:0] TAP_LIMIT_RST = 16'd500;
  localparam logic [15:0] CUE_RST = 16'd1000;
  localparam logic [15:0] DENY_RST = 16'd2000;

  // The percentage quotient is below 100 whenever a division runs, so seven bits suffice.
  localparam int unsigned DIV_STEPS = 7;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam logic [6:0] PCT_FULL = 7'd100;

  typedef enum logic [1:0] {
    DEC_NONE  = 2'd0,
    DEC_ALLOW = 2'd1,
    DEC_DENY  = 2'd2
  } decision_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic out_load;
  } thd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic out_free;
  } thd_sts_t;

endpackage

`default_nettype wire

>>> rtl/thd_ctrl.sv
// Controller state machine that sequences accept, multiply, divide and output load.
`default_nettype none

module thd_ctrl
  import thd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire thd_sts_t sts_i,
  output thd_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        if (sts_i.need_div) begin
          cmd_o.mul = 1'b1;
          cnt_d     = '0;
          state_d   = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/thd_datapath.sv
// Datapath: press state, threshold classification, percentage divider and output register.
`default_nettype none

module thd_datapath
  import thd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire thd_cmd_t    cmd_i,
  output thd_sts_t         sts_o,
  input  wire logic [15:0] tap_limit_i,
  input  wire logic [15:0] cue_i,
  input  wire logic [15:0] deny_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        prompt_present_i,
  input  wire logic        prompt_new_i,
  input  wire logic        press_edge_i,
  input  wire logic        button_down_i,
  input  wire logic        release_edge_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       decision_o,
  output logic             halfway_cue_o,
  output logic [6:0]       hold_percent_o
);

  // Persistent classifier state.
  logic [31:0] press_start_q, press_start_d;
  logic        press_active_q, press_active_d;
  logic        deny_done_q, deny_done_d;
  logic        cue_done_q, cue_done_d;
  logic        answered_q, answered_d;

  // Per-item results held until the output register is loaded.
  decision_e   dec_q, dec_d;
  logic        cue_q, cue_d;
  logic        need_q, need_d;
  logic        sat_q, sat_d;
  logic [15:0] held_lo_q;

  // Divider registers.
  logic [15:0] rem_q;
  logic [6:0]  dq_q;

  logic        out_valid_q;
  logic [1:0]  out_dec_q;
  logic        out_cue_q;
  logic [6:0]  out_pct_q;

  // Classification of one poll, evaluated on the input fields.
  logic        fresh, active, start;
  logic        ans1, pa1, dd1, pa2, dd2, hold_chk, fire_cue, fire_deny, rel, allow;
  logic [31:0] held;

  always_comb begin
    fresh  = prompt_present_i & prompt_new_i;
    ans1   = (fresh | ~prompt_present_i) ? 1'b0 : answered_q;
    pa1    = fresh ? 1'b0 : press_active_q;
    dd1    = fresh ? 1'b0 : deny_done_q;
    active = prompt_present_i & ~ans1;
    start  = active & press_edge_i;

    press_start_d = start ? now_ms_i : press_start_q;
    pa2           = start | pa1;
    dd2           = start ? 1'b0 : dd1;
    held          = now_ms_i - press_start_d;

    hold_chk  = active & pa2 & ~dd2 & button_down_i;
    fire_cue  = hold_chk & (held >= {16'd0, cue_i}) & ~cue_done_q;
    fire_deny = hold_chk & (held >= {16'd0, deny_i});

    if (fire_deny) begin
      cue_done_d = 1'b0;
    end else if (fire_cue) begin
      cue_done_d = 1'b1;
    end else begin
      cue_done_d = cue_done_q;
    end
    deny_done_d = fire_deny | dd2;

    rel   = active & ~fire_deny & release_edge_i & pa2;
    allow = rel & ~dd2 & (held < {16'd0, tap_limit_i});

    press_active_d = rel ? 1'b0 : pa2;
    answered_d     = ans1 | fire_deny | allow;

    if (fire_deny) begin
      dec_d = DEC_DENY;
    end else if (allow) begin
      dec_d = DEC_ALLOW;
    end else begin
      dec_d = DEC_NONE;
    end
    cue_d  = fire_cue;
    need_d = prompt_present_i & press_active_d & ~deny_done_d;
    sat_d  = held >= {16'd0, deny_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_start_q  <= '0;
      press_active_q <= 1'b0;
      deny_done_q    <= 1'b0;
      cue_done_q     <= 1'b0;
      answered_q     <= 1'b0;
    end else if (cmd_i.accept) begin
      press_start_q  <= press_start_d;
      press_active_q <= press_active_d;
      deny_done_q    <= deny_done_d;
      cue_done_q     <= cue_done_d;
      answered_q     <= answered_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dec_q     <= dec_d;
      cue_q     <= cue_d;
      need_q    <= need_d;
      sat_q     <= sat_d;
      held_lo_q <= held[15:0];
    end
  end

  // When not saturated the held time is below deny_ms, so it fits in 16 bits.
  logic [22:0] product;
  logic [16:0] trial;
  logic        q_bit;

  always_comb begin
    product = 23'(held_lo_q) * 23'(PCT_FULL);
    trial   = {rem_q, dq_q[6]};
    q_bit   = trial >= {1'b0, deny_i};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q <= product[22:7];
      dq_q  <= product[6:0];
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? 16'(trial - {1'b0, deny_i}) : trial[15:0];
      dq_q  <= {dq_q[5:0], q_bit};
    end
  end

  // Output register.
  logic [6:0] pct_sel;

  always_comb begin
    if (!need_q) begin
      pct_sel = '0;
    end else if (sat_q) begin
      pct_sel = PCT_FULL;
    end else begin
      pct_sel = dq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_dec_q <= dec_q;
      out_cue_q <= cue_q;
      out_pct_q <= pct_sel;
    end
  end

  assign sts_o.need_div = need_q & ~sat_q;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign decision_o     = out_dec_q;
  assign halfway_cue_o  = out_cue_q;
  assign hold_percent_o = out_pct_q;

endmodule

`default_nettype wire

>>> rtl/tap_hold_decision_classifier_unit.sv
// Top level of the tap/hold decision classifier: register port, controller and datapath.
`default_nettype none

// Channel   Direction  Handshake             Payload
// poll      in         in_valid_i/in_ready_o now_ms, prompt_present, prompt_new,
//                                            press_edge, button_down, release_edge
// result    out        out_valid_o/out_ready_i decision, halfway_cue, hold_percent
// config    in         APB psel/penable      tap_limit_ms, cue_ms, deny_ms
//
// A poll transfer is classified in the cycle it is accepted; the press state is updated
// at that edge. The hold percentage then takes one multiply step and seven steps of a
// restoring divider when a percentage must be divided out; when it is zero or saturated
// at 100 both are skipped. The controller is not ready again until the result is loaded.
// The result sits in an output register; the next poll is accepted while it waits.
// The output register only stalls the controller when a new result is ready and the old
// one has not been taken. Reset clears the press state and loads the register defaults.
module tap_hold_decision_classifier_unit
  import thd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Poll channel.
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic              prompt_present_i,
  input  wire logic              prompt_new_i,
  input  wire logic              press_edge_i,
  input  wire logic              button_down_i,
  input  wire logic              release_edge_i,
  // Result channel.
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             decision_o,
  output logic                   halfway_cue_o,
  output logic [6:0]             hold_percent_o,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Configuration registers. A write lands on the access cycle; unused word slots are
  // ignored on write and read back as zero.
  logic [15:0] tap_limit_q, cue_q, deny_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_limit_q <= TAP_LIMIT_RST;
      cue_q       <= CUE_RST;
      deny_q      <= DENY_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TAP_LIMIT: tap_limit_q <= pwdata[15:0];
        REG_CUE:       cue_q       <= pwdata[15:0];
        REG_DENY:      deny_q      <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TAP_LIMIT: prdata = {16'd0, tap_limit_q};
      REG_CUE:       prdata = {16'd0, cue_q};
      REG_DENY:      prdata = {16'd0, deny_q};
      default:       prdata = '0;
    endcase
  end

  // The controller sequences one poll at a time; the datapath holds the classifier state.
  thd_cmd_t cmd;
  thd_sts_t sts;

  thd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  thd_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .tap_limit_i      (tap_limit_q),
    .cue_i            (cue_q),
    .deny_i           (deny_q),
    .now_ms_i         (now_ms_i),
    .prompt_present_i (prompt_present_i),
    .prompt_new_i     (prompt_new_i),
    .press_edge_i     (press_edge_i),
    .button_down_i    (button_down_i),
    .release_edge_i   (release_edge_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .decision_o       (decision_o),
    .halfway_cue_o    (halfway_cue_o),
    .hold_percent_o   (hold_percent_o)
  );

  // Once a poll is taken, the controller must be busy on the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("controller ready right after a poll transfer");

  // The percentage never exceeds full scale.
  a_pct_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hold_percent_o <= PCT_FULL))
    else $error("hold percentage above 100");

  // A deny ends the hold, so it never carries a nonzero percentage.
  a_deny_no_pct : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && decision_o == DEC_DENY) |-> (hold_percent_o == 7'd0))
    else $error("deny result with nonzero hold percentage");

  // An output load only happens when the output register can take it.
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> !$past(cmd.out_load))
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the tap/hold decision classifier unit.
`timescale 1ns / 1ps

module testbench;
  import thd_pkg::*;

  // One poll as the sender presents it, and one classified result.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        prompt_present;
    logic        prompt_new;
    logic        press_edge;
    logic        button_down;
    logic        release_edge;
  } poll_t;

  typedef struct packed {
    decision_e  decision;
    logic       halfway_cue;
    logic [6:0] hold_percent;
  } result_t;

  // The scoreboard carries its own copy of the thresholds and of the press state.
  // Each accepted poll is classified at once, and the answer waits in a queue until
  // the block delivers its result.
  class decision_scoreboard;
    logic [15:0] tap_limit;
    logic [15:0] cue_limit;
    logic [15:0] deny_limit;
    logic [31:0] hold_start;
    logic        holding;
    logic        deny_sent;
    logic        cue_sent;
    logic        settled;
    result_t     awaited_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned allows;
    int unsigned denies;
    int unsigned cues;

    function new();
      tap_limit  = TAP_LIMIT_RST;
      cue_limit  = CUE_RST;
      deny_limit = DENY_RST;
      hold_start = '0;
      holding    = 1'b0;
      deny_sent  = 1'b0;
      cue_sent   = 1'b0;
      settled    = 1'b0;
      errors     = 0;
      checked    = 0;
      allows     = 0;
      denies     = 0;
      cues       = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) begin
        $display("ERROR @%0t: %s", $realtime, msg);
      end
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_TAP_LIMIT: tap_limit = value;
        REG_CUE:       cue_limit = value;
        default:       deny_limit = value;
      endcase
    endfunction

    // Progress toward deny, saturated at 100; the product is formed in 64 bits.
    function logic [6:0] hold_progress(logic [31:0] held);
      logic [63:0] quotient;
      if (deny_limit == 16'd0) begin
        return PCT_FULL;
      end
      quotient = ({32'd0, held} * 64'd100) / {48'd0, deny_limit};
      return (quotient > 64'd100) ? PCT_FULL : quotient[6:0];
    endfunction

    function void note_poll(poll_t p);
      result_t     r;
      logic [31:0] held;
      r = '0;
      // A new prompt only counts while a prompt is present.
      if (p.prompt_present && p.prompt_new) begin
        settled   = 1'b0;
        holding   = 1'b0;
        deny_sent = 1'b0;
      end
      if (!p.prompt_present) begin
        settled = 1'b0;
      end
      if (p.prompt_present && !settled) begin
        if (p.press_edge) begin
          hold_start = p.now_ms;
          holding    = 1'b1;
          deny_sent  = 1'b0;
        end
        if (holding && !deny_sent && p.button_down) begin
          held = p.now_ms - hold_start;
          if (held >= {16'd0, cue_limit} && !cue_sent) begin
            r.halfway_cue = 1'b1;
            cue_sent      = 1'b1;
          end
          if (held >= {16'd0, deny_limit}) begin
            r.decision = DEC_DENY;
            settled    = 1'b1;
            deny_sent  = 1'b1;
            cue_sent   = 1'b0;
          end
        end
        if (r.decision == DEC_NONE && p.release_edge && holding) begin
          held    = p.now_ms - hold_start;
          holding = 1'b0;
          if (!deny_sent && held < {16'd0, tap_limit}) begin
            r.decision = DEC_ALLOW;
            settled    = 1'b1;
          end
        end
      end
      if (p.prompt_present && holding && !deny_sent) begin
        r.hold_percent = hold_progress(p.now_ms - hold_start);
      end
      if (r.decision == DEC_ALLOW) allows++;
      if (r.decision == DEC_DENY) denies++;
      if (r.halfway_cue) cues++;
      awaited_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_q.size() == 0) begin
        flag($sformatf("result with nothing pending: decision %0d cue %0d percent %0d",
                       got.decision, got.halfway_cue, got.hold_percent));
        return;
      end
      want = awaited_q.pop_front();
      checked++;
      if (got.decision !== want.decision || got.halfway_cue !== want.halfway_cue ||
          got.hold_percent !== want.hold_percent) begin
        flag($sformatf("result %0d: expected decision %0d cue %0d percent %0d, got %0d %0d %0d",
                       checked, want.decision, want.halfway_cue, want.hold_percent,
                       got.decision, got.halfway_cue, got.hold_percent));
      end
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction
  endclass

  localparam int unsigned HOLD_OFF_CYCLES = 300;   // long receiver stall
  localparam int unsigned STALL_LIMIT     = 4000;  // cycles without any transfer
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned SETTLE_CYCLES   = 30;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [31:0]       now_ms_i;
  logic              prompt_present_i;
  logic              prompt_new_i;
  logic              press_edge_i;
  logic              button_down_i;
  logic              release_edge_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        decision_o;
  logic              halfway_cue_o;
  logic [6:0]        hold_percent_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  decision_scoreboard sb = new();

  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned hold_off_requests;
  int unsigned polls_sent;
  int unsigned quiet_cycles;
  logic [31:0] clock_ms;
  result_t     seen_result;

  tap_hold_decision_classifier_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .now_ms_i         (now_ms_i),
    .prompt_present_i (prompt_present_i),
    .prompt_new_i     (prompt_new_i),
    .press_edge_i     (press_edge_i),
    .button_down_i    (button_down_i),
    .release_edge_i   (release_edge_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .decision_o       (decision_o),
    .halfway_cue_o    (halfway_cue_o),
    .hold_percent_o   (hold_percent_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Everything is driven at the rising edge and sampled at the falling edge, so a
  // handshake seen at the falling edge is the one that completes at the next rising
  // edge, whatever order the simulator picks within a time step.

  // Receiver: random ready, except for a long hold-off whenever the main sequence
  // asks for one. The hold-off is counted here so the sender keeps running.
  initial begin
    int unsigned hold_off_served;
    hold_off_served = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_served != hold_off_requests) begin
        hold_off_served++;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Result monitor.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result.decision     = decision_e'(decision_o);
      seen_result.halfway_cue  = halfway_cue_o;
      seen_result.hold_percent = hold_percent_o;
      sb.check_result(seen_result);
    end
  end

  // Watchdog: the run is declared hung when the count of quiet cycles, with no transfer
  // of any kind, reaches STALL_LIMIT.
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one poll and returns at the rising edge where it is taken. Valid is left
  // high; the next call or the caller decides whether it drops.
  task automatic send_poll(input poll_t p);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    now_ms_i         <= p.now_ms;
    prompt_present_i <= p.prompt_present;
    prompt_new_i     <= p.prompt_new;
    press_edge_i     <= p.press_edge;
    button_down_i    <= p.button_down;
    release_edge_i   <= p.release_edge;
    do @(negedge clk_i); while (!in_ready_o);
    sb.note_poll(p);
    polls_sent++;
    @(posedge clk_i);
  endtask

  task automatic poll_at(input logic [31:0] stamp, input logic present, input logic fresh,
                         input logic press, input logic down, input logic lift);
    poll_t p;
    p.now_ms         = stamp;
    p.prompt_present = present;
    p.prompt_new     = fresh;
    p.press_edge     = press;
    p.button_down    = down;
    p.release_edge   = lift;
    send_poll(p);
  endtask

  // One APB access, with psel dropped again before the task returns; the write lands at the access edge.
  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [15:0] value,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_register(input logic [1:0] idx, input logic [15:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, value, rd);
    sb.set_register(idx, value);
    apb_access(1'b0, idx, 16'h0000, rd);
    if (rd[15:0] !== value) begin
      sb.flag($sformatf("register %0d reads back %0h, wrote %0h", idx, rd[15:0], value));
    end
  endtask

  task automatic program_thresholds(input logic [15:0] tap, input logic [15:0] cue,
                                    input logic [15:0] deny);
    program_register(REG_TAP_LIMIT, tap);
    program_register(REG_CUE, cue);
    program_register(REG_DENY, deny);
  endtask

  // Stops offering polls until every pending result has been delivered.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Scale for timestamp steps, so that holds reach each threshold under any setting.
  function automatic int unsigned threshold_span();
    int unsigned span;
    span = 32'(sb.deny_limit);
    if (32'(sb.cue_limit) > span) span = 32'(sb.cue_limit);
    if (32'(sb.tap_limit) > span) span = 32'(sb.tap_limit);
    return (span < 8) ? 8 : span;
  endfunction

  // Mostly complete press/hold/release episodes on a rising millisecond clock, with
  // some fully random polls mixed in as noise and as broken sequences.
  task automatic random_episode();
    int unsigned span;
    int unsigned holds;
    poll_t       p;
    span = threshold_span();
    if ($urandom_range(99) < 12) begin
      p.now_ms         = $urandom;
      p.prompt_present = 1'($urandom_range(1));
      p.prompt_new     = 1'($urandom_range(1));
      p.press_edge     = 1'($urandom_range(1));
      p.button_down    = 1'($urandom_range(1));
      p.release_edge   = 1'($urandom_range(1));
      send_poll(p);
    end else begin
      clock_ms += $urandom_range(0, span);
      if ($urandom_range(3) == 0) begin
        poll_at(clock_ms, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      end
      poll_at(clock_ms, 1'b1, $urandom_range(4) != 0, 1'b1, 1'b1, $urandom_range(9) == 0);
      holds = $urandom_range(5);
      repeat (holds) begin
        clock_ms += $urandom_range(0, span / 3);
        poll_at(clock_ms, $urandom_range(19) != 0, $urandom_range(19) == 0,
                $urandom_range(19) == 0, 1'b1, 1'b0);
      end
      if ($urandom_range(9) < 7) begin
        clock_ms += $urandom_range(1) ? $urandom_range(0, sb.tap_limit) : $urandom_range(0, span);
        poll_at(clock_ms, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
      end
    end
  endtask

  // Directed polls under the reset thresholds (tap 500, cue 1000, deny 2000). The
  // first press starts just below the 32-bit wrap so its hold spans the rollover.
  task automatic directed_polls();
    logic [31:0] t0;
    t0 = 32'hFFFF_FF00;
    poll_at(32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);         // idle, nothing pending
    poll_at(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1); // no prompt: flags ignored
    poll_at(t0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);            // new prompt
    poll_at(t0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);            // press
    poll_at(t0 + 32'd300, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);  // held, partial progress
    poll_at(t0 + 32'd400, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);  // quick release across wrap
    poll_at(t0 + 32'd500, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);  // answered: press ignored
    poll_at(32'd1000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);      // new prompt with press
    poll_at(32'd2000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);      // halfway cue
    poll_at(32'd2600, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);      // late release cancels
    poll_at(32'd3000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);      // new prompt with press
    poll_at(32'd4500, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);      // cue remembered, silent
    poll_at(32'd5000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);      // deny, cue memory cleared
    poll_at(32'd5500, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);      // answered, nothing happens
    poll_at(32'd6000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);      // prompt gone: answer cleared
    poll_at(32'd6100, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);      // same prompt, press again
    poll_at(32'd8200, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);      // cue and deny together
    poll_at(32'd9000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);      // press and release at once
    poll_at(32'd20000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);     // press
    poll_at(32'd23000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);     // not held: progress saturates
    poll_at(32'd23001, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);     // held again: cue and deny
    poll_at(32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0); // press mid-range
    poll_at(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0); // held time wraps huge: deny
  endtask

  initial begin
    int unsigned target;
    in_valid_i        = 1'b0;
    now_ms_i          = '0;
    prompt_present_i  = 1'b0;
    prompt_new_i      = 1'b0;
    press_edge_i      = 1'b0;
    button_down_i     = 1'b0;
    release_edge_i    = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    rst_ni            = 1'b0;
    quiet_cycles      = 0;
    polls_sent        = 0;
    hold_off_requests = 0;
    sender_idle_pct   = 24;
    receiver_idle_pct = 87;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_polls();

    // Six threshold settings: reset values, all at one, all at full scale, all zero
    // (deny and cue on the first held poll, no allow), a lopsided mix, and random.
    // The sender/receiver idle pattern swaps after the second setting; both idle rates drop to zero after the fourth.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        wait_for_results();
        case (phase)
          1: program_thresholds(16'd1, 16'd1, 16'd1);
          2: program_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
          3: program_thresholds(16'd0, 16'd0, 16'd0);
          4: program_thresholds(16'hFFFF, 16'd1, 16'd700);
          default: program_thresholds(16'($urandom_range(1, 65535)),
                                      16'($urandom_range(1, 65535)),
                                      16'($urandom_range(1, 65535)));
        endcase
      end
      if (phase == 2) begin
        sender_idle_pct   = 87;
        receiver_idle_pct = 24;
      end else if (phase == 4) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      // Each phase starts close to the timestamp wrap with even odds.
      clock_ms = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 4 * threshold_span());
      // Starve the result side while polls keep coming, so the unit backs up.
      if (phase == 1 || phase == 4) begin
        hold_off_requests <= hold_off_requests + 1;
      end
      target = polls_sent + ITEMS_PER_PHASE;
      while (polls_sent < target) random_episode();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
    end

    $display("Sent %0d polls through six threshold settings, from zero to full scale, with wrap.",
             polls_sent);
    $display("Checked %0d results: %0d allow, %0d deny, %0d halfway cues; %0d errors.",
             sb.checked, sb.allows, sb.denies, sb.cues, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
